FILE: hdl/ba_pkg.sv
// Shared constants and types for the buddy allocator.
`default_nettype none
package ba_pkg;
	localparam int MIN_ORDER    = 4;
	localparam int MAX_ORDER    = 12;
	localparam int HEADER_BYTES = 9;
	localparam int UNIT_BITS    = MAX_ORDER - MIN_ORDER;
	localparam int UNITS        = 1 << UNIT_BITS;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOSPC  = 2'd1;
	localparam logic [1:0] ST_BADOFF = 2'd2;
	localparam logic [1:0] ST_DBLFREE = 2'd3;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic [0:0] CFG_FIT    = 1'b0;
	localparam logic [0:0] CFG_REGION = 1'b1;

	typedef logic [5:0] entry_t;
	typedef logic [UNIT_BITS-1:0] unit_t;
endpackage
`default_nettype wire

FILE: hdl/buddy_allocator.sv
// Buddy allocator top level: table memory plus a sequencer over one shared unit.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | kind, request_bytes, payload_offset_in
//  out     | output    | out_valid/out_stall| status, payload_offset_out
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// An allocate reads and evaluates each block visited in the walk (up to 256), then
// writes one split level per step; a free reads and evaluates the buddy per merge level.
// The table memory has one write port and one read port with a registered result.
// After reset or a region_order write a clearing pass over all 256 entries runs with in_stall high.
// The result is held in an output register until taken; the next item is accepted after that.
`default_nettype none
module buddy_allocator (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        kind,
	input  wire [15:0] request_bytes,
	input  wire [11:0] payload_offset_in,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [1:0] status,
	output logic [11:0] payload_offset_out,
	input  wire        cfg_we,
	input  wire [0:0]  cfg_index,
	input  wire [3:0]  cfg_data
);
	import ba_pkg::*;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_ARD   = 4'd2;
	localparam logic [3:0] S_AEV   = 4'd3;
	localparam logic [3:0] S_SPLIT = 4'd4;
	localparam logic [3:0] S_FRD   = 4'd5;
	localparam logic [3:0] S_FEV   = 4'd6;
	localparam logic [3:0] S_BRD   = 4'd7;
	localparam logic [3:0] S_BEV   = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;
	localparam logic [3:0] S_FWR   = 4'd10;

	entry_t      mem [UNITS];
	entry_t      rd_q;
	logic [3:0]  state_q;
	logic [1:0]  fit_q;
	logic [3:0]  rord_q;
	logic [UNIT_BITS:0] clr_q;
	logic [UNIT_BITS:0] u_q;
	logic [UNIT_BITS:0] best_q;
	logic [3:0]  bk_q;
	logic [3:0]  k_q;
	logic        found_q;
	logic [UNIT_BITS:0] bu_q;
	logic [1:0]  st_q;
	logic [11:0] off_q;
	logic        vld_q;

	logic [3:0]  rord_eff;
	logic [UNIT_BITS:0] nunits;
	logic        we;
	unit_t       waddr;
	entry_t      wdata;
	unit_t       raddr;
	logic [UNIT_BITS:0] units_o;
	logic [16:0] total;
	logic [4:0]  k_need;
	logic [12:0] foff;
	logic        take;

	function automatic logic [UNIT_BITS:0] units_of(input logic [3:0] o);
		if (o <= 4'(MIN_ORDER)) return (UNIT_BITS+1)'(1);
		return (UNIT_BITS+1)'(1) << (o - 4'(MIN_ORDER));
	endfunction

	always_comb begin
		rord_eff = rord_q;
		if (rord_q < 4'(MIN_ORDER)) rord_eff = 4'(MIN_ORDER);
		if (rord_q > 4'(MAX_ORDER)) rord_eff = 4'(MAX_ORDER);
	end
	assign nunits = units_of(rord_eff);
	assign units_o = units_of(rd_q[3:0]);
	assign total = {1'b0, request_bytes} + 17'(HEADER_BYTES);
	always_comb begin
		k_need = 5'(MIN_ORDER);
		for (int i = MIN_ORDER; i < 17; i++)
			if ((17'(1) << i) < total) k_need = 5'(i + 1);
	end
	assign foff = {1'b0, payload_offset_in} - 13'(HEADER_BYTES);
	assign in_stall = (state_q != S_IDLE) || vld_q;
	assign take = in_valid && !in_stall;

	// write port and read address selection
	always_comb begin
		we = 1'b0; waddr = '0; wdata = '0;
		raddr = u_q[UNIT_BITS-1:0];
		case (state_q)
			S_CLR: begin
				we = 1'b1; waddr = clr_q[UNIT_BITS-1:0];
				wdata = (clr_q == '0) ? {2'b10, rord_eff} : '0;
			end
			S_SPLIT: begin
				we = 1'b1;
				if (bk_q > k_q) begin
					waddr = 8'(best_q + units_of(bk_q - 4'd1));
					wdata = {2'b10, bk_q - 4'd1};
				end else begin
					waddr = best_q[UNIT_BITS-1:0];
					wdata = {2'b11, k_q};
				end
			end
			S_BRD: raddr = bu_q[UNIT_BITS-1:0];
			S_BEV: begin
				if (rd_q[5] && !rd_q[4] && rd_q[3:0] == k_q) begin
					we = 1'b1;
					waddr = (bu_q < u_q) ? u_q[UNIT_BITS-1:0] : bu_q[UNIT_BITS-1:0];
				end else begin
					we = 1'b1; waddr = u_q[UNIT_BITS-1:0]; wdata = {2'b10, k_q};
				end
			end
			S_FEV: begin
				if (rd_q[5] && rd_q[4] && !(rd_q[3:0] < rord_eff)) begin
					we = 1'b1; waddr = u_q[UNIT_BITS-1:0]; wdata = {2'b10, rd_q[3:0]};
				end
			end
			// merged up to the whole region
			S_FWR: begin
				we = 1'b1; waddr = u_q[UNIT_BITS-1:0]; wdata = {2'b10, k_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; fit_q <= FIT_FIRST; rord_q <= 4'd12;
			clr_q <= '0; vld_q <= 1'b0; u_q <= '0;
		end else begin
			if (vld_q && !out_stall) vld_q <= 1'b0;
			if (cfg_we && cfg_index == CFG_FIT) fit_q <= cfg_data[1:0];
			if (cfg_we && cfg_index == CFG_REGION) begin
				rord_q <= cfg_data; clr_q <= '0; state_q <= S_CLR;
			end else case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (UNIT_BITS+1)'(UNITS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: if (take) begin
					off_q <= '0;
					if (!kind) begin
						k_q <= k_need[3:0]; u_q <= '0; found_q <= 1'b0;
						if (k_need > {1'b0, rord_eff}) begin
							st_q <= ST_NOSPC; state_q <= S_DONE;
						end else state_q <= S_ARD;
					end else begin
						if (payload_offset_in < 12'(HEADER_BYTES) || foff[MIN_ORDER-1:0] != '0
							|| (foff >> rord_eff) != '0) begin
							st_q <= ST_BADOFF; state_q <= S_DONE;
						end else begin
							u_q <= foff[UNIT_BITS+MIN_ORDER:MIN_ORDER]; state_q <= S_FRD;
						end
					end
				end
				S_ARD: begin
					if (u_q >= nunits) begin
						if (found_q) state_q <= S_SPLIT;
						else begin st_q <= ST_NOSPC; state_q <= S_DONE; end
					end else state_q <= S_AEV;
				end
				S_AEV: begin
					state_q <= S_ARD;
					u_q <= u_q + units_o;
					if (!rd_q[4] && rd_q[3:0] >= k_q) begin
						if (fit_q == FIT_BEST) begin
							if (!found_q || rd_q[3:0] < bk_q) begin
								best_q <= u_q; bk_q <= rd_q[3:0]; found_q <= 1'b1;
							end
						end else if (fit_q == FIT_WORST) begin
							if (!found_q || rd_q[3:0] > bk_q) begin
								best_q <= u_q; bk_q <= rd_q[3:0]; found_q <= 1'b1;
							end
						end else begin
							best_q <= u_q; bk_q <= rd_q[3:0]; found_q <= 1'b1;
							state_q <= S_SPLIT;
						end
					end
				end
				S_SPLIT: begin
					if (bk_q > k_q) bk_q <= bk_q - 4'd1;
					else begin
						st_q <= ST_OK;
						off_q <= 12'({best_q, MIN_ORDER'(0)} + (UNIT_BITS+1+MIN_ORDER)'(HEADER_BYTES));
						state_q <= S_DONE;
					end
				end
				S_FRD: state_q <= S_FEV;
				S_FEV: begin
					if (!rd_q[5]) begin st_q <= ST_BADOFF; state_q <= S_DONE; end
					else if (!rd_q[4]) begin st_q <= ST_DBLFREE; state_q <= S_DONE; end
					else begin
						k_q <= rd_q[3:0];
						bu_q <= u_q ^ units_of(rd_q[3:0]);
						if (rd_q[3:0] < rord_eff) state_q <= S_BRD;
						else begin st_q <= ST_OK; state_q <= S_DONE; end
					end
				end
				S_BRD: state_q <= S_BEV;
				S_BEV: begin
					if (rd_q[5] && !rd_q[4] && rd_q[3:0] == k_q) begin
						if (bu_q < u_q) u_q <= bu_q;
						k_q <= k_q + 4'd1;
						bu_q <= ((bu_q < u_q) ? bu_q : u_q) ^ units_of(k_q + 4'd1);
						if (k_q + 4'd1 < rord_eff) state_q <= S_BRD;
						else state_q <= S_FWR;
					end else begin
						st_q <= ST_OK; state_q <= S_DONE;
					end
				end
				S_FWR: begin
					st_q <= ST_OK; state_q <= S_DONE;
				end
				S_DONE: if (!vld_q) begin
					vld_q <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = vld_q;
	assign status = st_q;
	assign payload_offset_out = off_q;

	a_ok_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> payload_offset_out == '0) else $error("offset on failure");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accept while result pending");
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> in_stall) else $error("accept during clear");
endmodule
`default_nettype wire

FILE: sim/ba_checker.sv
// Watches the allocator channels, predicts each result and compares it.
`default_nettype none
module ba_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  wire        in_stall,
	input  wire        kind,
	input  wire [15:0] request_bytes,
	input  wire [11:0] payload_offset_in,
	input  wire        out_valid,
	input  wire        out_stall,
	input  wire [1:0]  status,
	input  wire [11:0] payload_offset_out,
	input  wire        cfg_we,
	input  wire [0:0]  cfg_index,
	input  wire [3:0]  cfg_data,
	output int         pending,
	output int         fails
);
	import ba_pkg::*;

	typedef struct packed {
		logic [1:0]  st;
		logic [11:0] off;
	} alloc_result_t;

	localparam logic [5:0] E_START = 6'h20;
	localparam logic [5:0] E_OCC   = 6'h10;

	entry_t        blocks [UNITS];
	logic [1:0]    fit_sel;
	logic [3:0]    region_sel;
	alloc_result_t expected_q[$];

	function automatic int unsigned clamp_region();
		int unsigned r;
		r = region_sel;
		if (r < MIN_ORDER) r = MIN_ORDER;
		if (r > MAX_ORDER) r = MAX_ORDER;
		return r;
	endfunction

	function automatic int unsigned span_units(int unsigned o);
		if (o <= MIN_ORDER) return 1;
		if (o - MIN_ORDER > 30) return UNITS;
		return 1 << (o - MIN_ORDER);
	endfunction

	function automatic void clear_blocks();
		foreach (blocks[i]) blocks[i] = '0;
		blocks[0] = E_START | 6'(clamp_region());
	endfunction

	function automatic alloc_result_t predict_alloc(int unsigned bytes);
		alloc_result_t res;
		int unsigned total, k, rord, nunits, u, pick, pick_k, o, bu;
		logic [5:0] e;
		bit found;
		res = '0;
		total = bytes + HEADER_BYTES;
		k = MIN_ORDER;
		rord = clamp_region();
		nunits = span_units(rord);
		u = 0; pick = 0; pick_k = 0; found = 0;
		while (k < 31 && (1 << k) < total) k++;
		if (k > rord) begin
			res.st = ST_NOSPC;
			return res;
		end
		while (u < nunits) begin
			e = blocks[u % UNITS];
			o = e[3:0];
			if (!e[4] && o >= k) begin
				if (fit_sel == FIT_BEST) begin
					if (!found || o < pick_k) begin pick = u; pick_k = o; found = 1; end
				end else if (fit_sel == FIT_WORST) begin
					if (!found || o > pick_k) begin pick = u; pick_k = o; found = 1; end
				end else begin
					pick = u; pick_k = o; found = 1;
					break;
				end
			end
			u += span_units(o);
		end
		if (!found) begin
			res.st = ST_NOSPC;
			return res;
		end
		while (pick_k > k) begin
			pick_k--;
			bu = pick + span_units(pick_k);
			blocks[bu % UNITS] = E_START | 6'(pick_k & 15);
		end
		blocks[pick % UNITS] = E_START | E_OCC | 6'(k & 15);
		res.st = ST_OK;
		res.off = 12'((pick << MIN_ORDER) + HEADER_BYTES);
		return res;
	endfunction

	function automatic alloc_result_t predict_free(int unsigned poff);
		alloc_result_t res;
		int unsigned rord, off, u, k, bu;
		logic [5:0] e, be;
		res = '0;
		rord = clamp_region();
		if (poff < HEADER_BYTES) begin res.st = ST_BADOFF; return res; end
		off = poff - HEADER_BYTES;
		if ((off % (1 << MIN_ORDER)) != 0 || off >= (1 << rord)) begin
			res.st = ST_BADOFF;
			return res;
		end
		u = off >> MIN_ORDER;
		e = blocks[u % UNITS];
		if (!e[5]) begin res.st = ST_BADOFF; return res; end
		if (!e[4]) begin res.st = ST_DBLFREE; return res; end
		k = e[3:0];
		while (k < rord) begin
			bu = u ^ span_units(k);
			if (bu >= span_units(rord)) break;
			be = blocks[bu % UNITS];
			if (!be[5] || be[4] || be[3:0] != k) break;
			if (bu < u) begin
				blocks[u % UNITS] = '0;
				u = bu;
			end else begin
				blocks[bu % UNITS] = '0;
			end
			k++;
		end
		blocks[u % UNITS] = E_START | 6'(k & 15);
		res.st = ST_OK;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fit_sel = FIT_FIRST;
			region_sel = 4'd12;
			clear_blocks();
			expected_q.delete();
			pending <= 0;
			fails <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FIT) begin
					fit_sel = cfg_data[1:0];
				end else if (cfg_index == CFG_REGION) begin
					region_sel = cfg_data;
					clear_blocks();
				end
			end
			if (in_valid && !in_stall) begin
				if (kind) expected_q = {expected_q, predict_free(payload_offset_in)};
				else expected_q = {expected_q, predict_alloc(request_bytes)};
			end
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result status %0d offset %0d",
						$time, status, payload_offset_out);
					errs++;
				end else begin
					want = expected_q.pop_front();
					if (want.st !== status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.st, status);
						errs++;
					end
					if (want.off !== payload_offset_out) begin
						$display("%0t: offset expected %0d actual %0d",
							$time, want.off, payload_offset_out);
						errs++;
					end
				end
			end
			fails <= fails + errs;
			pending <= expected_q.size();
		end
	end
endmodule
`default_nettype wire

FILE: sim/tb.sv
// Stimulus and verdict for the buddy allocator.
`default_nettype none
module tb;
	import ba_pkg::*;

	localparam int CYCLE_LIMIT = 5000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        kind = 0;
	logic [15:0] request_bytes = 0;
	logic [11:0] payload_offset_in = 0;
	logic        out_stall = 0;
	logic        cfg_we = 0;
	logic [0:0]  cfg_index = CFG_FIT;
	logic [3:0]  cfg_data = 0;
	wire         in_stall, out_valid;
	wire  [1:0]  status;
	wire  [11:0] payload_offset_out;
	int          pending, fails;
	int          cycles = 0;
	int          idle_pct = 28;
	bit          kind_q[$];
	logic [11:0] live_offsets[$];

	always #2 clk = ~clk;

	buddy_allocator u_dut (
		.clk, .arst_n, .in_valid, .in_stall, .kind, .request_bytes, .payload_offset_in,
		.out_valid, .out_stall, .status, .payload_offset_out, .cfg_we, .cfg_index, .cfg_data
	);

	ba_checker u_chk (
		.clk, .arst_n, .in_valid, .in_stall, .kind, .request_bytes, .payload_offset_in,
		.out_valid, .out_stall, .status, .payload_offset_out, .cfg_we, .cfg_index, .cfg_data,
		.pending, .fails
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver stalls, and remembers granted blocks for later frees
	always @(posedge clk) begin
		bit k;
		if (arst_n) begin
			out_stall <= ($urandom_range(0, 99) < idle_pct);
			if (in_valid && !in_stall) kind_q = {kind_q, kind};
			if (out_valid && !out_stall && kind_q.size() > 0) begin
				k = kind_q.pop_front();
				if (!k && status == ST_OK) live_offsets = {live_offsets, payload_offset_out};
			end
		end
	end

	task automatic send(input bit k, input logic [15:0] bytes, input logic [11:0] poff);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		request_bytes <= bytes;
		payload_offset_in <= poff;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0 || kind_q.size() != 0) @(posedge clk);
	endtask

	task automatic configure(input logic [1:0] fit, input logic [3:0] region);
		drain();
		cfg_we <= 1;
		cfg_index <= CFG_FIT;
		cfg_data <= {2'b00, fit};
		@(posedge clk);
		cfg_index <= CFG_REGION;
		cfg_data <= region;
		@(posedge clk);
		cfg_we <= 0;
		live_offsets.delete();
	endtask

	task automatic random_item();
		int r, idx;
		logic [15:0] bytes;
		logic [11:0] poff;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			r = $urandom_range(0, 9);
			if (r < 6) bytes = 16'($urandom_range(0, 40));
			else if (r < 9) bytes = 16'($urandom_range(0, 600));
			else bytes = 16'($urandom());
			send(0, bytes, 12'($urandom()));
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70 && live_offsets.size() > 0) begin
				idx = $urandom_range(0, live_offsets.size() - 1);
				poff = live_offsets[idx];
				if ($urandom_range(0, 99) < 85) live_offsets.delete(idx);
			end else if (r < 85) begin
				poff = 12'(($urandom_range(0, 255) << MIN_ORDER) + HEADER_BYTES);
			end else begin
				poff = 12'($urandom());
			end
			send(1, 16'($urandom()), poff);
		end
	endtask

	initial begin
		logic [3:0] regions[14] = '{12, 4, 15, 0, 5, 8, 10, 12, 6, 9, 11, 12, 7, 3};
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// directed: reset settings, whole region at order 12
		send(0, 16'd0, 12'd0);
		send(0, 16'hFFFF, 12'd0);
		send(0, 16'd4087, 12'd0);
		send(1, 16'd0, 12'd8);
		send(1, 16'd0, 12'd10);
		send(1, 16'd0, 12'd9);
		send(1, 16'd0, 12'd9);
		send(1, 16'd0, 12'd25);
		send(1, 16'd0, 12'hFFF);
		send(0, 16'd4087, 12'd0);
		send(1, 16'd0, 12'd9);
		// best and worst fit ties on a fragmented region
		configure(FIT_BEST, 4'd8);
		send(0, 16'd7, 12'd0);
		send(0, 16'd7, 12'd0);
		send(0, 16'd50, 12'd0);
		send(1, 16'd0, 12'd9);
		send(0, 16'd7, 12'd0);
		configure(FIT_WORST, 4'd8);
		send(0, 16'd7, 12'd0);
		send(0, 16'd7, 12'd0);
		send(0, 16'd7, 12'd0);
		configure(2'd3, 4'd0);
		send(0, 16'd7, 12'd0);
		send(0, 16'd7, 12'd0);
		send(1, 16'd0, 12'd25);
		configure(FIT_FIRST, 4'd15);
		send(0, 16'd4087, 12'd0);
		send(0, 16'd0, 12'd0);

		for (int p = 0; p < 14; p++) begin
			configure(2'(p % 4), regions[p]);
			idle_pct = (p == 5) ? 0 : 28;
			for (int i = 0; i < 100; i++) begin
				if (p == 2 && i == 50) drain();
				random_item();
			end
		end
		drain();
		repeat (40) @(posedge clk);
		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
